// File: rtl/core/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg: shared types for the time-ordered event queue
// Operation codes, sequencer states and the fixed kind-field width.
// ----------------------------------------------------------------------------
`default_nettype none

package toeq_pkg;

  localparam int unsigned KIND_BITS = 2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_HEAD,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/time_ordered_event_queue.sv
// Sequencing: a push runs IDLE, SCAN (one compare-and-shift step per later event; none
//   if empty), INS or DONE; pop/peek IDLE, HEAD, DONE; clear, failed ops IDLE, DONE.
// Requests are handled one at a time; the next request is taken once the current one
//   has moved into the output register.
// Reset: asynchronous, active low; clears fill count, head index and handshake state.
//   The event memory is not cleared; only slots that hold queued events are read.
// ----------------------------------------------------------------------------
// time_ordered_event_queue: bounded queue of timed events, earliest first
// Events live in a ring held in one synchronous memory. A push walks back from
// the tail, shifting later events one slot toward the tail until it finds an
// event of equal or earlier time, then drops the new event in behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module time_ordered_event_queue #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned TIME_BITS    = 32,
  parameter int unsigned PAYLOAD_BITS = 48
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // request channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  toeq_pkg::op_e                      op_i,
  input  wire  [TIME_BITS-1:0]               event_time_i,
  input  wire  [toeq_pkg::KIND_BITS-1:0]     event_kind_i,
  input  wire  [PAYLOAD_BITS-1:0]            event_payload_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               ok_o,
  output logic [TIME_BITS-1:0]               head_time_o,
  output logic [toeq_pkg::KIND_BITS-1:0]     head_kind_o,
  output logic [PAYLOAD_BITS-1:0]            head_payload_o,
  output logic [$clog2(CAPACITY+1)-1:0]      fill_count_o
);

  import toeq_pkg::*;

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W  = KIND_BITS + PAYLOAD_BITS;
  localparam int unsigned ENTRY_W = TIME_BITS + DATA_W;
  localparam logic [CNT_W:0]   CAP_S  = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(CAPACITY - 1);

  // Step one slot forward or back around the ring.
  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] x);
    ring_inc = (x == LAST_I) ? '0 : x + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] x);
    ring_dec = (x == '0) ? LAST_I : x - IDX_W'(1);
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [DATA_W-1:0]   data_q, data_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0]    rem_q, rem_d;

  // pending result, moved to the output register when it is free
  logic                res_ok_q, res_ok_d;
  logic [TIME_BITS-1:0] res_time_q, res_time_d;
  logic [DATA_W-1:0]   res_data_q, res_data_d;

  logic                out_valid_q, out_valid_d;
  logic                ok_q, ok_d;
  logic [TIME_BITS-1:0] ht_q, ht_d;
  logic [DATA_W-1:0]   hd_q, hd_d;
  logic [CNT_W-1:0]    fc_q, fc_d;

  // memory port
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]  rd_data_q;

  logic [ENTRY_W-1:0]  mem_q [CAPACITY];

  logic [CNT_W:0]      tail_sum;
  logic [IDX_W-1:0]    tail_idx;
  logic [TIME_BITS-1:0] rd_time;
  logic                in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Ring slot just past the last queued event.
  always_comb begin
    tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(cnt_q);
    if (tail_sum >= CAP_S) begin
      tail_sum = tail_sum - CAP_S;
    end
    tail_idx = tail_sum[IDX_W-1:0];
  end

  assign rd_time = rd_data_q[ENTRY_W-1 -: TIME_BITS];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    time_d     = time_q;
    data_d     = data_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    cur_d      = cur_q;
    rem_d      = rem_q;
    res_ok_d   = res_ok_q;
    res_time_d = res_time_q;
    res_data_d = res_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d       = ok_q;
    ht_d       = ht_q;
    hd_d       = hd_q;
    fc_d       = fc_q;
    mem_we     = 1'b0;
    mem_waddr  = cur_q;
    mem_wdata  = {time_q, data_q};
    mem_re     = 1'b0;
    mem_raddr  = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // latch the request; head fields of the result default to zero
          op_d       = op_i;
          time_d     = event_time_i;
          data_d     = {event_kind_i, event_payload_i};
          res_ok_d   = 1'b0;
          res_time_d = '0;
          res_data_d = '0;
          case (op_i)
            OP_PUSH: begin
              if (cnt_q == CAP_C) begin
                state_d = ST_DONE;
              end else if (cnt_q == '0) begin
                cur_d   = tail_idx;
                state_d = ST_INS;
              end else begin
                // start the backward scan at the last queued event
                cur_d     = tail_idx;
                rem_d     = cnt_q;
                mem_re    = 1'b1;
                mem_raddr = ring_dec(tail_idx);
                state_d   = ST_SCAN;
              end
            end
            OP_POP, OP_PEEK: begin
              if (cnt_q == '0) begin
                state_d = ST_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                state_d   = ST_HEAD;
              end
            end
            OP_CLEAR: begin
              head_d   = '0;
              cnt_d    = '0;
              res_ok_d = 1'b1;
              state_d  = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // rd_data_q holds the event just in front of cur_q
        if (rd_time > time_q) begin
          // shift the later event one slot toward the tail
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          mem_wdata = rd_data_q;
          cur_d     = ring_dec(cur_q);
          rem_d     = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_INS;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ring_dec(ring_dec(cur_q));
          end
        end else begin
          // equal or earlier time: insert behind it
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          cnt_d     = cnt_q + CNT_W'(1);
          res_ok_d  = 1'b1;
          state_d   = ST_DONE;
        end
      end

      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q;
        cnt_d     = cnt_q + CNT_W'(1);
        res_ok_d  = 1'b1;
        state_d   = ST_DONE;
      end

      ST_HEAD: begin
        res_ok_d   = 1'b1;
        res_time_d = rd_time;
        res_data_d = rd_data_q[DATA_W-1:0];
        if (op_q == OP_POP) begin
          head_d = ring_inc(head_q);
          cnt_d  = cnt_q - CNT_W'(1);
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          ht_d        = res_time_q;
          hd_d        = res_data_q;
          fc_d        = cnt_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    time_q     <= time_d;
    data_q     <= data_d;
    cur_q      <= cur_d;
    rem_q      <= rem_d;
    res_ok_q   <= res_ok_d;
    res_time_q <= res_time_d;
    res_data_q <= res_data_d;
    ok_q       <= ok_d;
    ht_q       <= ht_d;
    hd_q       <= hd_d;
    fc_q       <= fc_d;
  end

  // --------------------------------------------------------------------------
  // Event memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign head_time_o    = ht_q;
  assign head_kind_o    = hd_q[DATA_W-1 -: KIND_BITS];
  assign head_payload_o = hd_q[PAYLOAD_BITS-1:0];
  assign fill_count_o   = fc_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("fill count exceeds capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W + 1)'(head_q) < CAP_S)
    else $error("head index outside the ring");

  a_scan_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rem_q != '0) && (mem_raddr != mem_waddr || !mem_re))
    else $error("scan with no events left or read/write on the same slot");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == OP_CLEAR) |=> (cnt_q == '0) && (state_q == ST_DONE))
    else $error("clear did not empty the queue");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == OP_PUSH && cnt_q == CAP_C) |=> $stable(cnt_q) && !res_ok_q)
    else $error("push to a full queue changed the queue");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for time_ordered_event_queue
// Drives push, pop, peek and clear requests through a valid/ready handshake,
// predicts each result with a sorted-timeline model (or takes a result typed into
// the table) and compares each result field by field. A directed table runs first, then random fill, drain and
// mixed episodes under varying sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import toeq_pkg::*;

  localparam int CAPACITY        = 64;
  localparam int TIME_W          = 32;
  localparam int PAY_W           = 48;
  localparam int FILL_W          = $clog2(CAPACITY + 1);
  localparam int RANDOM_ITEMS    = 880;
  localparam int HOLD_AT         = 300;   // random request index that starts the long hold-off
  localparam int DRAIN_AT        = 600;   // random request index that waits for an empty pipe
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 80;    // room for the longest push scan
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 50;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    EPISODE_FILL,
    EPISODE_DRAIN,
    EPISODE_MIX
  } episode_e;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] at;
    logic [1:0]        kind;
    logic [PAY_W-1:0]  data;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [TIME_W-1:0] at;
    logic [1:0]        kind;
    logic [PAY_W-1:0]  data;
    logic [FILL_W-1:0] fill;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] at;
    logic [1:0]        kind;
    logic [PAY_W-1:0]  data;
  } sched_event_t;

  typedef struct packed {
    req_t    req;
    logic    fixed;   // result typed in by hand instead of predicted
    result_t want;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // Clock and DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  op_e               op_i            = OP_PUSH;
  logic [TIME_W-1:0] event_time_i    = '0;
  logic [1:0]        event_kind_i    = '0;
  logic [PAY_W-1:0]  event_payload_i = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic              ok_o;
  logic [TIME_W-1:0] head_time_o;
  logic [1:0]        head_kind_o;
  logic [PAY_W-1:0]  head_payload_o;
  logic [FILL_W-1:0] fill_count_o;

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  time_ordered_event_queue #(
    .CAPACITY     (CAPACITY),
    .TIME_BITS    (TIME_W),
    .PAYLOAD_BITS (PAY_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .event_time_i    (event_time_i),
    .event_kind_i    (event_kind_i),
    .event_payload_i (event_payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .head_time_o     (head_time_o),
    .head_kind_o     (head_kind_o),
    .head_payload_o  (head_payload_o),
    .fill_count_o    (fill_count_o)
  );

  // --------------------------------------------------------------------------
  // Bench state: predicted timeline, pending results, idling knobs, counters
  // --------------------------------------------------------------------------
  sched_event_t timeline[$];          // predicted queue contents, earliest first
  result_t      expected_results[$];  // results owed by the DUT, oldest first

  int  snd_idle_pct     = 0;
  int  rcv_stall_pct    = 0;
  bit  hold_off_pending = 1'b0;
  int  mismatches       = 0;
  int  results_seen     = 0;
  int  requests_sent    = 0;
  int  pushes_ok        = 0;
  int  full_rejects     = 0;
  int  empty_rejects    = 0;
  int  clears           = 0;
  int  peak_fill        = 0;
  int  cycles           = 0;

  // --------------------------------------------------------------------------
  // Predictor: apply one request to the timeline and return its result
  // --------------------------------------------------------------------------
  function automatic result_t predict_request(input req_t r);
    result_t      res;
    sched_event_t ev;
    int           pos;
    res = '0;
    ev  = '{at: r.at, kind: r.kind, data: r.data};
    case (r.op)
      OP_PUSH: begin
        if (timeline.size() < CAPACITY) begin
          // Walk back from the tail past every strictly later event, so a tie
          // lands behind the events already stored at that time.
          pos = timeline.size();
          for (int i = timeline.size() - 1; i >= 0 && timeline[i].at > r.at; i--) begin
            pos = i;
          end
          timeline.insert(pos, ev);
          res.ok = 1'b1;
          pushes_ok++;
        end else begin
          full_rejects++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (timeline.size() != 0) begin
          res.ok   = 1'b1;
          res.at   = timeline[0].at;
          res.kind = timeline[0].kind;
          res.data = timeline[0].data;
          if (r.op == OP_POP) begin
            void'(timeline.pop_front());
          end
        end else begin
          empty_rejects++;
        end
      end
      default: begin
        timeline.delete();
        res.ok = 1'b1;
        clears++;
      end
    endcase
    res.fill = FILL_W'(timeline.size());
    if (timeline.size() > peak_fill) begin
      peak_fill = timeline.size();
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Table helpers
  // --------------------------------------------------------------------------
  function automatic result_t outcome(input logic ok, input logic [TIME_W-1:0] at,
                                      input logic [1:0] kind, input logic [PAY_W-1:0] data,
                                      input logic [FILL_W-1:0] fill);
    return '{ok: ok, at: at, kind: kind, data: data, fill: fill};
  endfunction

  function automatic plan_row_t plan_row(input op_e op, input logic [TIME_W-1:0] at,
                                         input logic [1:0] kind,
                                         input logic [PAY_W-1:0] data,
                                         input logic fixed, input result_t want);
    plan_row_t row;
    row.req   = '{op: op, at: at, kind: kind, data: data};
    row.fixed = fixed;
    row.want  = want;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Random request generation, biased by episode
  // --------------------------------------------------------------------------
  function automatic req_t random_request(input episode_e episode,
                                          input logic [TIME_W-1:0] tie_base);
    req_t        r;
    int unsigned roll;
    logic [63:0] bits64;
    roll   = $urandom_range(0, 99);
    bits64 = {$urandom, $urandom};
    case (episode)
      EPISODE_FILL:  r.op = (roll < 88) ? OP_PUSH : (roll < 94) ? OP_POP : OP_PEEK;
      EPISODE_DRAIN: r.op = (roll < 12) ? OP_PUSH : (roll < 80) ? OP_POP :
                            (roll < 97) ? OP_PEEK : OP_CLEAR;
      default:       r.op = (roll < 45) ? OP_PUSH : (roll < 75) ? OP_POP :
                            (roll < 95) ? OP_PEEK : OP_CLEAR;
    endcase
    // Cluster times around a shared base often enough to build runs of ties.
    case ($urandom_range(0, 7))
      3, 4:    r.at = tie_base + $urandom_range(0, 3);
      5:       r.at = $urandom_range(0, 15);
      6:       r.at = 32'hFFFF_FFFF - $urandom_range(0, 3);
      7:       r.at = tie_base;
      default: r.at = $urandom;
    endcase
    r.kind = 2'($urandom_range(0, 3));
    r.data = bits64[PAY_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  task automatic set_idling(input idle_mode_e mode);
    snd_idle_pct  = (mode == IDLE_SENDER)   ? 52 : (mode == IDLE_BOTH) ? 28 : 0;
    rcv_stall_pct = (mode == IDLE_RECEIVER) ? 52 : (mode == IDLE_BOTH) ? 28 : 0;
  endtask

  // Offer one request, hold it until accepted, then log what it must return.
  task automatic issue_request(input req_t r, input logic fixed, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= r.op;
    event_time_i    <= r.at;
    event_kind_i    <= r.kind;
    event_payload_i <= r.data;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predicted = predict_request(r);
    expected_results.push_back(fixed ? want : predicted);
    requests_sent++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
               $time, what, got, want, results_seen);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off that backs up the block
  // --------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_pending = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{ok: ok_o, at: head_time_o, kind: head_kind_o, data: head_payload_o,
              fill: fill_count_o};
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending (fill)", 64'(got.fill), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.ok   !== want.ok)   report_mismatch("ok",           64'(got.ok),   64'(want.ok));
        if (got.at   !== want.at)   report_mismatch("head_time",    64'(got.at),   64'(want.at));
        if (got.kind !== want.kind) report_mismatch("head_kind",    64'(got.kind), 64'(want.kind));
        if (got.data !== want.data) report_mismatch("head_payload", 64'(got.data), 64'(want.data));
        if (got.fill !== want.fill) report_mismatch("fill_count",   64'(got.fill), 64'(want.fill));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: bound the run well above the slowest legal schedule
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycles, expected_results.size());
      $display("** time_ordered_event_queue: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random episodes, then drain and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t         plan[$];
    episode_e          episode;
    int                episode_len;
    int                rnd_sent;
    logic [TIME_W-1:0] tie_base;

    // Directed table. Typed results cover the empty queue after reset, the
    // extreme field values, the empty-queue rejects and clears; the rest follow the predictor.
    plan.push_back(plan_row(OP_POP,   32'd0, 2'd0, 48'd0, 1'b1, outcome(0, 0, 0, 0, 0)));
    plan.push_back(plan_row(OP_PEEK,  32'd0, 2'd0, 48'd0, 1'b1, outcome(0, 0, 0, 0, 0)));
    plan.push_back(plan_row(OP_CLEAR, 32'd0, 2'd0, 48'd0, 1'b1, outcome(1, 0, 0, 0, 0)));
    // Largest time, largest kind and all-ones payload travel unchanged.
    plan.push_back(plan_row(OP_PUSH, 32'hFFFF_FFFF, 2'd3, 48'hFFFF_FFFF_FFFF,
                            1'b1, outcome(1, 0, 0, 0, 1)));
    plan.push_back(plan_row(OP_PEEK, 32'd0, 2'd0, 48'd0, 1'b1,
                            outcome(1, 32'hFFFF_FFFF, 2'd3, 48'hFFFF_FFFF_FFFF, 1)));
    plan.push_back(plan_row(OP_PUSH, 32'd0, 2'd0, 48'd0, 1'b1, outcome(1, 0, 0, 0, 2)));
    plan.push_back(plan_row(OP_PEEK, 32'd0, 2'd0, 48'd0, 1'b1, outcome(1, 0, 0, 0, 2)));
    // Three events at the same time must pop in arrival order.
    plan.push_back(plan_row(OP_PUSH, 32'd100, 2'd1, 48'hAAAA_AAAA_AAAA, 1'b0, '0));
    plan.push_back(plan_row(OP_PUSH, 32'd100, 2'd2, 48'h5555_5555_5555, 1'b0, '0));
    plan.push_back(plan_row(OP_PUSH, 32'd100, 2'd0, 48'h0000_0000_0001, 1'b0, '0));
    plan.push_back(plan_row(OP_PUSH, 32'd99,  2'd2, 48'h1234_5678_9ABC, 1'b0, '0));
    plan.push_back(plan_row(OP_PUSH, 32'h8000_0000, 2'd1, 48'h8000_0000_0000, 1'b0, '0));
    repeat (7) plan.push_back(plan_row(OP_POP, 32'd0, 2'd0, 48'd0, 1'b0, '0));
    plan.push_back(plan_row(OP_POP,   32'd0, 2'd0, 48'd0, 1'b1, outcome(0, 0, 0, 0, 0)));
    plan.push_back(plan_row(OP_PUSH,  32'd7, 2'd1, 48'h0000_0000_DEAD, 1'b0, '0));
    plan.push_back(plan_row(OP_PUSH,  32'd7, 2'd3, 48'h0000_0000_BEEF, 1'b0, '0));
    plan.push_back(plan_row(OP_CLEAR, 32'd0, 2'd0, 48'd0, 1'b1, outcome(1, 0, 0, 0, 0)));
    plan.push_back(plan_row(OP_PEEK,  32'd0, 2'd0, 48'd0, 1'b1, outcome(0, 0, 0, 0, 0)));

    // Hold reset low from time zero, then release it for good.
    set_idling(IDLE_NONE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      issue_request(plan[i].req, plan[i].fixed, plan[i].want);
    end
    pause_until_drained();

    // Random episodes: fill runs push past capacity, drain runs empty the
    // queue and hit empty rejects, mixed runs interleave everything. Rotate
    // the idling mode every 110 requests.
    rnd_sent = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: episode = EPISODE_FILL;
        4, 5, 6:    episode = EPISODE_DRAIN;
        default:    episode = EPISODE_MIX;
      endcase
      episode_len = $urandom_range(20, 90);
      tie_base    = $urandom;
      for (int k = 0; k < episode_len && rnd_sent < RANDOM_ITEMS; k++) begin
        set_idling(idle_mode_e'((rnd_sent / 110) % 4));
        if (rnd_sent == HOLD_AT) begin
          hold_off_pending = 1'b1;
        end
        if (rnd_sent == DRAIN_AT) begin
          pause_until_drained();
        end
        issue_request(random_request(episode, tie_base), 1'b0, '0);
        rnd_sent++;
      end
    end

    // Drain everything owed, then give the block time to show stray results.
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);
    end

    $display("ran %0d requests, checked %0d results in %0d cycles", requests_sent,
             results_seen, cycles);
    $display("pushes stored %0d, full rejects %0d, empty rejects %0d, clears %0d, peak fill %0d",
             pushes_ok, full_rejects, empty_rejects, clears, peak_fill);
    if (mismatches == 0) begin
      $display("** time_ordered_event_queue: PASSED **");
    end else begin
      $display("** time_ordered_event_queue: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
